>>> src/cdi_pkg.sv
package cdi_pkg;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic [2:0] FN_READ        = 3'd0;
	localparam logic [2:0] FN_OVERWRITE   = 3'd1;
	localparam logic [2:0] FN_ADD_HIGH    = 3'd2;
	localparam logic [2:0] FN_ADD_LOW     = 3'd3;
	localparam logic [2:0] FN_REMOVE_HIGH = 3'd4;
	localparam logic [2:0] FN_REMOVE_LOW  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]            func;
		logic [PTR_W-1:0]      position;
		logic [ELEM_WIDTH-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [ELEM_WIDTH-1:0] result_value;
		logic [1:0]            status;
		logic [CNT_W-1:0]      occupancy_now;
	} rsp_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_RESP
	} ctl_state_t;

	typedef struct packed {
		logic exec;
	} ctl_cmd_t;

endpackage

>>> src/circular_deque_indexed_unit.sv
// circular deque with indexed access, capacity 16 elements of 32 bits
// request channel: req_valid / req_ready carry req (func, position, item_value)
//   func: read, overwrite, add high, add low, remove high, remove low
// response channel: rsp_valid / rsp_ready carry rsp (result_value, status,
//   occupancy_now), exactly one response per request, in request order
// a request is executed in the cycle it is accepted: the ring store, head
//   pointer and count update at that edge and the response register loads
// the response is valid from the cycle after the request is accepted
// throughput: one request per cycle while rsp_ready is high; a new request
//   is taken in the same cycle the pending response is taken, so the
//   one-entry response register sets the rate
// receiver stall: while rsp_valid is high and rsp_ready low, req_ready is
//   low and the response holds
// reset: arst_n clears head and count (empty deque), no response pending;
//   store contents need no clearing since only occupied slots are read
module circular_deque_indexed_unit
	import cdi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;

	cdi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	cdi_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> src/cdi_ctrl.sv
module cdi_ctrl
	import cdi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd.exec  = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				req_ready = 1'b1;
				cmd.exec  = req_valid;
				if (req_valid) begin
					state_d = CTL_RESP;
				end
			end
			CTL_RESP: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				cmd.exec  = req_valid && rsp_ready;
				if (rsp_ready && !req_valid) begin
					state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

endmodule

>>> src/cdi_datapath.sv
module cdi_datapath
	import cdi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	input  req_t     req,
	output rsp_t     rsp
);

	logic [ELEM_WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0]      head_q, head_d;
	logic [CNT_W-1:0]      count_q, count_d;
	rsp_t                  rsp_q, rsp_d;

	logic [CNT_W-1:0]      count_m1;
	logic [PTR_W-1:0]      head_dec, head_inc;
	logic [PTR_W-1:0]      rd_addr, wr_addr;
	logic [ELEM_WIDTH-1:0] rd_data;
	logic                  wr_en;
	logic                  is_full, is_empty, in_range;

	assign count_m1 = count_q - CNT_W'(1);
	assign head_dec = head_q - PTR_W'(1);
	assign head_inc = head_q + PTR_W'(1);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign in_range = ({1'b0, req.position} < count_q);

	// single read port address
	always_comb begin
		case (req.func)
			FN_REMOVE_HIGH: rd_addr = head_q + count_m1[PTR_W-1:0];
			FN_REMOVE_LOW:  rd_addr = head_q;
			default:        rd_addr = head_q + req.position;
		endcase
	end

	assign rd_data = store_q[rd_addr];

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		wr_en   = 1'b0;
		wr_addr = rd_addr;
		rsp_d.result_value = '0;
		rsp_d.status       = ST_OK;
		unique case (req.func) inside
			FN_READ, FN_OVERWRITE: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					rsp_d.result_value = rd_data;
					wr_en = (req.func == FN_OVERWRITE);
				end
			end
			FN_ADD_HIGH: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = head_q + count_q[PTR_W-1:0];
					count_d = count_q + CNT_W'(1);
					rsp_d.result_value = req.item_value;
				end
			end
			FN_ADD_LOW: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = head_dec;
					head_d  = head_dec;
					count_d = count_q + CNT_W'(1);
					rsp_d.result_value = req.item_value;
				end
			end
			FN_REMOVE_HIGH: begin
				if (is_empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					count_d = count_m1;
					rsp_d.result_value = rd_data;
				end
			end
			FN_REMOVE_LOW: begin
				if (is_empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					head_d  = head_inc;
					count_d = count_m1;
					rsp_d.result_value = rd_data;
				end
			end
			default: begin
			end
		endcase
		rsp_d.occupancy_now = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
			if (wr_en) begin
				store_q[wr_addr] <= req.item_value;
			end
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy above capacity");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_full && (req.func == FN_ADD_HIGH || req.func == FN_ADD_LOW)
		|=> $stable(count_q) && $stable(head_q) && rsp_q.status == ST_FULL)
		else $error("add on full changed state");

	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_empty
		&& (req.func == FN_REMOVE_HIGH || req.func == FN_REMOVE_LOW)
		|=> $stable(count_q) && $stable(head_q) && rsp_q.status == ST_EMPTY)
		else $error("remove on empty changed state");

	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_q.occupancy_now == count_q)
		else $error("reported occupancy differs from count");

endmodule
